// ===== design/kpi_pkg.sv =====
// Shared types and constants for the kernel projection index block.
// No dependencies; every other design file imports this package.
package kpi_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int NN_W       = 2 * CNT_W;
    localparam int OUT_W      = 80;

    localparam logic [31:0] INV_BW_RESET  = 32'd65536;
    localparam logic [31:0] FOUR_OVER_PI  = 32'd2734261102;
    localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             dropped;
    } job_t;

    typedef struct packed {
        logic [63:0]      sum;
        logic [CNT_W-1:0] n;
        logic             flag;
    } pair_res_t;

endpackage

// ===== design/kpi_queue.sv =====
// Two-entry job queue between the point loader and the pair engine.
// Depends on kpi_pkg for job_t.
module kpi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kpi_pkg::job_t push_job,
    input  logic          pop,
    output logic          not_empty,
    output kpi_pkg::job_t head_job
);
    import kpi_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign not_empty = (fill_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/kpi_front.sv =====
// Point loader: accepts points, writes the coordinate memories, issues jobs.
// Depends on kpi_pkg; read port is driven by the pair engine.
module kpi_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [kpi_pkg::COORD_W-1:0] x_coord,
    input  logic [kpi_pkg::COORD_W-1:0] y_coord,
    input  logic                       last_point,
    output logic                       job_push,
    output kpi_pkg::job_t              job,
    input  logic                       release_set,
    input  logic [kpi_pkg::ADDR_W-1:0] rd_addr,
    output logic [kpi_pkg::COORD_W-1:0] rd_x,
    output logic [kpi_pkg::COORD_W-1:0] rd_y
);
    import kpi_pkg::*;

    logic [COORD_W-1:0] x_mem [MAX_POINTS];
    logic [COORD_W-1:0] y_mem [MAX_POINTS];
    logic [CNT_W-1:0]   count_reg;
    logic               dropped_reg;
    logic               busy_reg;
    logic               accept;
    logic               full;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(MAX_POINTS));
    assign job_push = accept && last_point;
    assign job.n       = full ? count_reg : count_reg + CNT_W'(1);
    assign job.dropped = dropped_reg || full;

    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            x_mem[count_reg[ADDR_W-1:0]] <= x_coord;
            y_mem[count_reg[ADDR_W-1:0]] <= y_coord;
        end
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else if (job_push)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (release_set)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/kpi_pair.sv =====
// Pair engine: sweeps all ordered point pairs through a kernel pipeline.
// Depends on kpi_pkg; reads points from the loader's memory port.
module kpi_pair (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [31:0]                 inv_bw,
    input  logic                        job_valid,
    input  kpi_pkg::job_t               job,
    output logic                        job_pop,
    output logic [kpi_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [kpi_pkg::COORD_W-1:0] rd_x,
    input  logic [kpi_pkg::COORD_W-1:0] rd_y,
    output logic                        release_set,
    output logic                        res_valid,
    output kpi_pkg::pair_res_t          res,
    input  logic                        res_ready
);
    import kpi_pkg::*;

    typedef enum logic [5:0] {
        P_IDLE  = 6'b000001,
        P_LOADI = 6'b000010,
        P_WAITI = 6'b000100,
        P_SWEEP = 6'b001000,
        P_DRAIN = 6'b010000,
        P_HAND  = 6'b100000
    } pair_state_t;

    pair_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, i_reg, j_reg;
    logic               drop_reg;
    logic [COORD_W-1:0] xi_reg, yi_reg;
    logic [63:0]        sum_reg;
    logic               sat_reg;

    // pipeline valid bits, one per stage
    logic [7:1]  v_reg;
    logic [32:0] dx_reg, dy_reg;
    logic [63:0] ux_reg, uy_reg;
    logic        zx_reg, zy_reg, bx_reg, by_reg;
    logic [32:0] sx_reg, sy_reg;
    logic [31:0] t4_reg, t5_reg, t2_reg;
    logic        kill4_reg, one4_reg, kill5_reg, one5_reg;
    logic [32:0] k_reg;

    logic        last_col, last_row;
    logic [32:0] dx_s, dy_s;
    logic [33:0] r2;
    logic [63:0] sqx_full, sqy_full, t2_full;
    logic [63:0] t3_full;
    logic [64:0] sum_ext;

    assign last_col = (j_reg == n_reg - CNT_W'(1));
    assign last_row = (i_reg == n_reg - CNT_W'(1));
    assign rd_addr  = (state_reg == P_LOADI) ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];
    assign job_pop  = (state_reg == P_IDLE) && job_valid;
    assign release_set = (state_reg == P_SWEEP) && last_col && last_row;
    assign res_valid   = (state_reg == P_HAND);
    assign res.sum  = sum_reg;
    assign res.n    = n_reg;
    assign res.flag = sat_reg || drop_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE:  if (job_valid) state_next = P_LOADI;
            P_LOADI: state_next = P_WAITI;
            P_WAITI: state_next = P_SWEEP;
            P_SWEEP:
            begin
                if (last_col)
                begin
                    state_next = last_row ? P_DRAIN : P_LOADI;
                end
            end
            P_DRAIN: if (v_reg == '0) state_next = P_HAND;
            P_HAND:  if (res_ready) state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            v_reg     <= '0;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= {v_reg[6:1], (state_reg == P_SWEEP)};
            case (state_reg)
                P_IDLE:
                begin
                    if (job_valid)
                    begin
                        n_reg    <= job.n;
                        drop_reg <= job.dropped;
                        i_reg    <= '0;
                        sum_reg  <= '0;
                        sat_reg  <= 1'b0;
                    end
                end
                P_WAITI: j_reg <= '0;
                P_SWEEP:
                begin
                    j_reg <= j_reg + CNT_W'(1);
                    if (last_col)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
            // accumulate with saturation
            if (v_reg[7])
            begin
                if (sum_ext[64])
                begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_ext[63:0];
                end
            end
        end
    end

    assign dx_s     = {xi_reg[COORD_W-1], xi_reg} - {rd_x[COORD_W-1], rd_x};
    assign dy_s     = {yi_reg[COORD_W-1], yi_reg} - {rd_y[COORD_W-1], rd_y};
    assign r2       = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign sqx_full = ux_reg[31:0] * ux_reg[31:0];
    assign sqy_full = uy_reg[31:0] * uy_reg[31:0];
    assign t2_full  = t4_reg * t4_reg;
    assign t3_full  = t2_reg * t5_reg;
    assign sum_ext  = {1'b0, sum_reg} + {32'd0, k_reg};

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == P_WAITI)
        begin
            xi_reg <= rd_x;
            yi_reg <= rd_y;
        end
        // absolute differences
        dx_reg <= dx_s[32] ? -dx_s : dx_s;
        dy_reg <= dy_s[32] ? -dy_s : dy_s;
        // scale by inverse bandwidth
        ux_reg <= dx_reg[31:0] * inv_bw;
        uy_reg <= dy_reg[31:0] * inv_bw;
        zx_reg <= (dx_reg == '0) || (inv_bw == '0);
        zy_reg <= (dy_reg == '0) || (inv_bw == '0);
        bx_reg <= dx_reg[32];
        by_reg <= dy_reg[32];
        // per-axis square, ONE_Q32 marks out of range
        if (zx_reg)
            sx_reg <= '0;
        else if (bx_reg || (ux_reg[63:32] != '0))
            sx_reg <= ONE_Q32;
        else
            sx_reg <= {1'b0, sqx_full[63:32]};
        if (zy_reg)
            sy_reg <= '0;
        else if (by_reg || (uy_reg[63:32] != '0))
            sy_reg <= ONE_Q32;
        else
            sy_reg <= {1'b0, sqy_full[63:32]};
        // t = 1 - r2
        kill4_reg <= (r2[33:32] != 2'd0);
        one4_reg  <= (r2 == '0);
        t4_reg    <= 32'd0 - r2[31:0];
        // t squared
        t2_reg    <= t2_full[63:32];
        t5_reg    <= t4_reg;
        kill5_reg <= kill4_reg;
        one5_reg  <= one4_reg;
        // t cubed
        if (kill5_reg)
            k_reg <= '0;
        else if (one5_reg)
            k_reg <= ONE_Q32;
        else
            k_reg <= {1'b0, t3_full[63:32]};
    end

endmodule

// ===== design/kpi_finish.sv =====
// Final scaling: sum*inv_bw*inv_bw, divide by n*n, times 4/pi, saturate; output register.
// Depends on kpi_pkg; shares one 32x32 multiplier and a radix-2 divider.
module kpi_finish (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [31:0]                  inv_bw,
    input  logic                         res_valid,
    input  kpi_pkg::pair_res_t           res,
    output logic                         res_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kpi_pkg::OUT_W-1:0]    out_data
);
    import kpi_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL1 = 6'b000010,
        F_MUL2 = 6'b000100,
        F_DIV  = 6'b001000,
        F_MUL3 = 6'b010000,
        F_OUT  = 6'b100000
    } fin_state_t;

    fin_state_t       state_reg;
    logic [95:0]      ma_reg;
    logic [31:0]      mb_reg;
    logic [127:0]     acc_reg;
    logic [1:0]       word_reg;
    logic [NN_W-1:0]  nn_reg;
    logic [127:0]     div_reg;
    logic [NN_W-1:0]  rem_reg;
    logic [6:0]       step_reg;
    logic [CNT_W-1:0] n_reg;
    logic             flag_reg;
    logic [63:0]      result_reg;
    logic             out_valid_reg;

    logic [31:0]  ma_word;
    logic [63:0]  prod;
    logic [127:0] acc_next;
    logic [NN_W:0] shifted;
    logic          ge;
    logic [127:0]  div_next;

    assign res_ready = (state_reg == F_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (word_reg)
            2'd0:    ma_word = ma_reg[31:0];
            2'd1:    ma_word = ma_reg[63:32];
            default: ma_word = ma_reg[95:64];
        endcase
    end

    assign prod     = ma_word * mb_reg;
    assign acc_next = acc_reg + (128'(prod) << {word_reg, 5'd0});
    assign shifted  = {rem_reg, div_reg[127]};
    assign ge       = (shifted >= {1'b0, nn_reg});
    assign div_next = {div_reg[126:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                F_IDLE:
                begin
                    if (res_valid)
                    begin
                        word_reg  <= '0;
                        state_reg <= F_MUL1;
                    end
                end
                F_MUL1, F_MUL2, F_MUL3:
                begin
                    word_reg <= word_reg + 2'd1;
                    if (word_reg == 2'd2)
                    begin
                        word_reg <= '0;
                        case (state_reg)
                            F_MUL1:  state_reg <= F_MUL2;
                            F_MUL2:
                            begin
                                step_reg  <= '0;
                                state_reg <= F_DIV;
                            end
                            default: state_reg <= F_OUT;
                        endcase
                    end
                end
                F_DIV:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd127)
                    begin
                        state_reg <= (div_next[127:96] != '0) ? F_OUT : F_MUL3;
                    end
                end
                F_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                ma_reg   <= {32'd0, res.sum};
                mb_reg   <= inv_bw;
                acc_reg  <= '0;
                nn_reg   <= res.n * res.n;
                n_reg    <= res.n;
                flag_reg <= res.flag;
            end
            F_MUL1, F_MUL2, F_MUL3:
            begin
                acc_reg <= acc_next;
                if (word_reg == 2'd2)
                begin
                    acc_reg <= '0;
                    if (state_reg == F_MUL1)
                    begin
                        ma_reg <= acc_next[95:0];
                    end
                    else if (state_reg == F_MUL2)
                    begin
                        div_reg <= acc_next;
                        rem_reg <= '0;
                    end
                    else if (acc_next[127])
                    begin
                        result_reg <= '1;
                        flag_reg   <= 1'b1;
                    end
                    else
                    begin
                        result_reg <= acc_next[126:63];
                    end
                end
            end
            F_DIV:
            begin
                div_reg <= div_next;
                rem_reg <= ge ? NN_W'(shifted - {1'b0, nn_reg}) : shifted[NN_W-1:0];
                if (step_reg == 7'd127)
                begin
                    ma_reg <= div_next[95:0];
                    mb_reg <= FOUR_OVER_PI;
                    if (div_next[127:96] != '0)
                    begin
                        result_reg <= '1;
                        flag_reg   <= 1'b1;
                    end
                end
            end
            F_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_data <= {4'd0, flag_reg, n_reg, result_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/kernel_projection_index.sv =====
// Top level of the triweight-kernel projection pursuit index block.
// Depends on kpi_pkg, kpi_front, kpi_queue, kpi_pair and kpi_finish.
//
// Usage:
//   Stream points in on the s_ group, one point per transfer; s_tlast marks
//   the last point of a set. Up to 1024 points are kept; further points are
//   dropped and flagged. On the last point the set is handed to the pair
//   engine, which evaluates all n*n ordered pairs, one pair per cycle within
//   a row, from a single memory read port. The finish unit then runs three
//   3-step multiplies on one 32x32 multiplier and a 128-step radix-2 divide
//   (the third multiply is skipped if the quotient overflows) and presents
//   one result transfer on the m_ group.
//   s_tready drops after the last point of a set and returns once the pair
//   engine has issued its final memory read, so the next set may load while
//   the previous one is still being finished or waits at the output.
//   If the receiver stalls, the result holds in the output register; the
//   finish unit then waits, and so does the pair engine behind it.
//   Reset clears all control state, sets inv_bandwidth to 1.0 (Q16.16) and
//   needs no clearing pass. Write cfg_data only while the block is idle.
module kernel_projection_index (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,     // inv_bandwidth, unsigned Q16.16
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // [31:0] x_coord, [63:32] y_coord
    input  logic        s_tlast,      // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata       // [63:0] index_value, [74:64] point_count,
                                      // [75] overflow_flag, [79:76] zero
);
    import kpi_pkg::*;

    logic [31:0]        inv_bw_reg;
    logic               job_push, job_pop, job_avail, release_set;
    job_t               push_job, head_job;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COORD_W-1:0] rd_x, rd_y;
    logic               res_valid, res_ready;
    pair_res_t          res;

    // hold the bandwidth register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_bw_reg <= INV_BW_RESET;
        else if (cfg_we)
            inv_bw_reg <= cfg_data;
    end

    kpi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .x_coord     (s_tdata[31:0]),
        .y_coord     (s_tdata[63:32]),
        .last_point  (s_tlast),
        .job_push    (job_push),
        .job         (push_job),
        .release_set (release_set),
        .rd_addr     (rd_addr),
        .rd_x        (rd_x),
        .rd_y        (rd_y)
    );

    kpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (job_pop),
        .not_empty (job_avail),
        .head_job  (head_job)
    );

    kpi_pair u_pair (
        .clk         (clk),
        .rst_n       (rst_n),
        .inv_bw      (inv_bw_reg),
        .job_valid   (job_avail),
        .job         (head_job),
        .job_pop     (job_pop),
        .rd_addr     (rd_addr),
        .rd_x        (rd_x),
        .rd_y        (rd_y),
        .release_set (release_set),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    kpi_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_bw    (inv_bw_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // a result always reports at least one and at most the capacity of points
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[74:64] != 11'd0) && (m_tdata[74:64] <= 11'd1024))
        else $error("point_count out of range");

    // loader takes points only when no set is pending in the queue
    a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !job_avail)
        else $error("loader ready with a set pending");

    // closing a set stops further transfers at once
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("loader still ready after last point");

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for kernel_projection_index: directed point sets, one overfull set, then random sets.
// Depends on kpi_pkg and the kernel_projection_index RTL; reads no files.
`timescale 1ns / 100ps

module testbench;
    import kpi_pkg::*;

    localparam int  LIMIT_CYCLES = 4_000_000;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  RANDOM_ITEMS = 580;
    localparam int  HOLD_CYCLES  = 4000;

    typedef struct {
        logic [63:0]      index_value;
        logic [CNT_W-1:0] point_count;
        logic             overflow_flag;
    } index_res_t;

    typedef struct {
        bit          do_cfg;
        logic [31:0] bw;
        logic [31:0] x;
        logic [31:0] y;
        bit          last;
        bit          typed;
        index_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    kernel_projection_index uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow state of the block: point store, counters and bandwidth register.
    logic signed [63:0] x_pts [MAX_POINTS];
    logic signed [63:0] y_pts [MAX_POINTS];
    int unsigned        pts_loaded;
    bit                 pts_dropped;
    logic [31:0]        inv_bw;

    index_res_t  pending_idx [$];
    stim_row_t   dir_rows [$];
    int unsigned errors;
    int unsigned cycles;
    bit          hold_req;
    bit          quiet_send;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Squared scaled distance on one axis, Q0.32; ONE_Q32 stands for "at least 1".
    function automatic logic [63:0] axis_dist2(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] sq;
        d = a - b;
        if (d[63])
            d = -d;
        if (d == 0 || inv_bw == 0)
            return 64'd0;
        if (d >= ONE_Q32)
            return 64'(ONE_Q32);
        u = d * 64'(inv_bw);
        if (u >= ONE_Q32)
            return 64'(ONE_Q32);
        sq = u * u;
        return sq >> 32;
    endfunction

    function automatic logic [63:0] triweight(int unsigned i, int unsigned j);
        logic [63:0] r2;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t3;
        r2 = axis_dist2(x_pts[i], x_pts[j]) + axis_dist2(y_pts[i], y_pts[j]);
        if (r2 >= ONE_Q32)
            return 64'd0;
        t = 64'(ONE_Q32) - r2;
        if (t == ONE_Q32)
            return t;
        t2 = (t * t) >> 32;
        t3 = t2 * t;
        return t3 >> 32;
    endfunction

    // Load one point into the shadow store; on the last point compute the index.
    function automatic bit load_point(logic [31:0] x, logic [31:0] y, bit last,
                                      output index_res_t res);
        logic [63:0]  ksum;
        logic [63:0]  k;
        logic [127:0] prod;
        logic [127:0] quot;
        logic [127:0] scaled;
        bit           sat;
        int unsigned  n;
        if (pts_loaded < MAX_POINTS) begin
            x_pts[pts_loaded] = 64'(signed'(x));
            y_pts[pts_loaded] = 64'(signed'(y));
            pts_loaded++;
        end else
            pts_dropped = 1'b1;
        if (!last)
            return 1'b0;
        n = pts_loaded;
        ksum = 0;
        sat = 1'b0;
        for (int unsigned i = 0; i < n; i++)
            for (int unsigned j = 0; j < n; j++) begin
                k = triweight(i, j);
                if (ksum > 64'hFFFF_FFFF_FFFF_FFFF - k) begin
                    ksum = '1;
                    sat = 1'b1;
                end else
                    ksum += k;
            end
        prod = 128'(ksum) * 128'(inv_bw) * 128'(inv_bw);
        quot = prod / 128'(n * n);
        if (quot[127:96] != 0) begin
            res.index_value = '1;
            sat = 1'b1;
        end else begin
            scaled = quot * 128'(FOUR_OVER_PI);
            if (scaled[127]) begin
                res.index_value = '1;
                sat = 1'b1;
            end else
                res.index_value = scaled[126:63];
        end
        res.point_count   = CNT_W'(n);
        res.overflow_flag = pts_dropped | sat;
        pts_loaded  = 0;
        pts_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Short gaps mostly, now and then a long one; none while quiet_send is set.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_send || roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Write inv_bandwidth; call only with the block idle.
    task automatic write_bw(logic [31:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
        inv_bw   = value;
    endtask

    // Drop the offer, hold the sender until every expected result is back, then settle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (pending_idx.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Offer one point and hold it until the transfer happens.
    task automatic send_point(logic [31:0] x, logic [31:0] y, bit last,
                              bit typed, index_res_t typed_res);
        int unsigned gap;
        index_res_t  res;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {y, x};
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        if (load_point(x, y, last, res))
            pending_idx.push_back(typed ? typed_res : res);
    endtask

    task automatic add_row(bit do_cfg, logic [31:0] bw, logic [31:0] x, logic [31:0] y,
                           bit last, bit typed, logic [63:0] idx, int unsigned n, bit flag);
        stim_row_t r;
        r.do_cfg = do_cfg;
        r.bw     = bw;
        r.x      = x;
        r.y      = y;
        r.last   = last;
        r.typed  = typed;
        r.res.index_value   = idx;
        r.res.point_count   = CNT_W'(n);
        r.res.overflow_flag = flag;
        dir_rows.push_back(r);
    endtask

    // Random coordinate near a center, spread to about one and a half bandwidths so pairs land inside.
    function automatic logic [31:0] near(logic [31:0] center);
        logic [63:0] span;
        if (inv_bw == 0 || $urandom_range(0, 9) == 0)
            return $urandom();
        span = 64'(ONE_Q32) / 64'(inv_bw);
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        span = span + span / 2;
        return center + 32'($urandom_range(0, 32'(2 * span)) - 64'(span));
    endfunction

    task automatic send_set(int unsigned size, bit noise);
        logic [31:0] cx;
        logic [31:0] cy;
        index_res_t  none;
        none = '{default: '0};
        cx = $urandom();
        cy = $urandom();
        for (int unsigned i = 0; i < size; i++)
            if (noise)
                send_point($urandom(), $urandom(), i == size - 1, 1'b0, none);
            else
                send_point(near(cx), near(cy), i == size - 1, 1'b0, none);
    endtask

    function automatic logic [31:0] pick_bw();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return INV_BW_RESET;
            3:       return $urandom();
            default: return 32'($urandom_range(1 << 10, 1 << 22));
        endcase
    endfunction

    // Sender: reset, directed table, one overfull set, then random sets.
    initial
    begin
        int unsigned sent;
        int unsigned size;
        bit          held;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        hold_req = 1'b0;
        quiet_send = 1'b0;
        held = 1'b0;
        errors = 0;
        pts_loaded = 0;
        pts_dropped = 1'b0;
        inv_bw = INV_BW_RESET;

        // One point at reset bandwidth: the only pair adds 1.0, index = 4/pi in Q32.32.
        add_row(0, 0, 32'h0, 32'h0, 1, 1, 64'd5468522204, 1, 0);
        add_row(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h0001_0000, 32'hFFFF_8000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h0001_4000, 32'hFFFF_C000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h0000_C000, 32'hFFFF_9000, 1, 0, 0, 0, 0);
        // Narrowest bandwidth (largest inv_bandwidth) on coincident points: the result saturates.
        add_row(1, 32'hFFFF_FFFF, 32'd5, 32'd5, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'd5, 32'd5, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 2, 1);
        add_row(0, 0, 32'd5, 32'd6, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'd7, 32'd5, 1, 0, 0, 0, 0);
        // Zero inverse bandwidth: every pair counts fully but the index is zero.
        add_row(1, 32'h0, 32'd1, 32'd2, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'd100, 32'hFFFF_FFFD, 1, 1, 64'd0, 2, 0);
        add_row(1, 32'd1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0);
        add_row(1, 32'h0004_0000, 32'h0000_2000, 32'h0000_1000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h0000_3000, 32'hFFFF_F000, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'hFFFF_E000, 32'h0000_0800, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].do_cfg) begin
                wait_idle();
                write_bw(dir_rows[i].bw);
            end
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                       dir_rows[i].typed, dir_rows[i].res);
        end

        // Fill the store and push one more point: the extra point is dropped and flagged.
        wait_idle();
        write_bw(32'h0010_0000);
        quiet_send = 1'b1;
        send_set(MAX_POINTS + 1, 1'b0);
        quiet_send = 1'b0;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            write_bw(pick_bw());
            // Stall the receiver once and queue enough small sets behind it to block the input.
            if (!held && sent > RANDOM_ITEMS / 3) begin
                held = 1'b1;
                hold_req = 1'b1;
                repeat (6) begin
                    send_set(3, 1'b0);
                    sent += 3;
                end
            end
            repeat ($urandom_range(1, 4)) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
                send_set(size, $urandom_range(0, 5) == 0);
                sent += size;
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (pending_idx.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("kernel_projection_index: match");
        else
            $display("kernel_projection_index: mismatch");
        $finish;
    end

    // Receiver backpressure: short stalls, rare long ones, and one requested long hold-off.
    initial
    begin
        int unsigned stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall != 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                case ($urandom_range(0, 19))
                    0, 1, 2: stall = $urandom_range(1, 3);
                    3:       stall = $urandom_range(15, 80);
                    default: stall = 0;
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        index_res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_idx.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_idx.pop_front();
                if (m_tdata[63:0] !== want.index_value) begin
                    $display("%0t: index_value expected %h actual %h",
                             $time, want.index_value, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[64 +: CNT_W] !== want.point_count) begin
                    $display("%0t: point_count expected %0d actual %0d",
                             $time, want.point_count, m_tdata[64 +: CNT_W]);
                    errors++;
                end
                if (m_tdata[64 + CNT_W] !== want.overflow_flag) begin
                    $display("%0t: overflow_flag expected %b actual %b",
                             $time, want.overflow_flag, m_tdata[64 + CNT_W]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("kernel_projection_index: mismatch");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
